// ----- rtl/ssrg_pkg.sv -----
package ssrg_pkg;

  // Fixed field widths of the request channel, configuration port and table.
  localparam int unsigned KeyInW  = 32;
  localparam int unsigned SeqW    = 64;
  localparam int unsigned TimeW   = 32;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned LimitInW = 5;
  localparam int unsigned StampW   = 64;

  // Register indexes of the configuration port.
  localparam logic [CfgIdxW-1:0] REG_TTL   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_LIMIT = 2'd1;

  localparam logic [TimeW-1:0] TTL_RESET = 32'd30;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_COMMIT,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic scan;
    logic commit;
    logic out_valid;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_done;
  } status_t;

endpackage

// ----- rtl/ssrg_if.sv -----
interface ssrg_req_if;
  logic                          valid;
  logic                          ready;
  logic [ssrg_pkg::KeyInW-1:0]   session_key;
  logic [ssrg_pkg::SeqW-1:0]     sequence_number;
  logic [ssrg_pkg::TimeW-1:0]    now_sec;

  modport source (output valid, output session_key, output sequence_number,
                  output now_sec, input ready);
  modport sink (input valid, input session_key, input sequence_number,
                input now_sec, output ready);
endinterface

interface ssrg_res_if;
  logic valid;
  logic ready;
  logic accepted;
  logic new_session;
  logic evicted;

  modport source (output valid, output accepted, output new_session,
                  output evicted, input ready);
  modport sink (input valid, input accepted, input new_session,
                input evicted, output ready);
endinterface

// ----- rtl/session_sequence_replay_guard.sv -----
// Channel   Direction  Payload
// in_ch     sink       session_key, sequence_number, now_sec
// out_ch    source     accepted, new_session, evicted
// cfg_*     write      cfg_index selects ttl_seconds (0) or session_limit (1)
//
// The result is offered once a request has been accepted, scanned (one entry read
// per cycle, each entry evaluated from the read registers) and committed in a
// commit step. A new request is taken the cycle after the result has been
// delivered, so the block never holds more than one request at a time.
// Synchronous active-low reset empties the table and restores the registers.
// A stalled result holds in its register until out_ch.ready is high.
module session_sequence_replay_guard #(
  parameter int unsigned MAX_SESSIONS = 16,
  parameter int unsigned KEY_WIDTH    = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  ssrg_req_if.sink                      in_ch,
  ssrg_res_if.source                    out_ch,
  input  logic                          cfg_we,
  input  logic [ssrg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [ssrg_pkg::CfgDataW-1:0] cfg_data
);

  ssrg_pkg::cmd_t    cmd;
  ssrg_pkg::status_t status;

  ssrg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .status    (status),
    .cmd       (cmd),
    .in_ready  (in_ch.ready)
  );

  ssrg_datapath #(
    .N  (MAX_SESSIONS),
    .KW (KEY_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .status          (status),
    .in_key          (in_ch.session_key),
    .in_seq          (in_ch.sequence_number),
    .in_now          (in_ch.now_sec),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .res_accepted    (out_ch.accepted),
    .res_new_session (out_ch.new_session),
    .res_evicted     (out_ch.evicted)
  );

  assign out_ch.valid = cmd.out_valid;

endmodule

// ----- rtl/ssrg_ctrl.sv -----
module ssrg_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              out_ready,
  input  ssrg_pkg::status_t status,
  output ssrg_pkg::cmd_t    cmd,
  output logic              in_ready
);

  ssrg_pkg::state_t state_r, state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ssrg_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands.
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ssrg_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = ssrg_pkg::ST_SCAN;
        end
      end
      ssrg_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (status.scan_done) begin
          state_nxt = ssrg_pkg::ST_COMMIT;
        end
      end
      ssrg_pkg::ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt = ssrg_pkg::ST_OUT;
      end
      ssrg_pkg::ST_OUT: begin
        cmd.out_valid = 1'b1;
        if (out_ready) begin
          state_nxt = ssrg_pkg::ST_IDLE;
        end
      end
      default: state_nxt = ssrg_pkg::ST_IDLE;
    endcase
  end

endmodule

// ----- rtl/ssrg_datapath.sv -----
module ssrg_datapath #(
  parameter int unsigned N  = 16,
  parameter int unsigned KW = 32
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ssrg_pkg::cmd_t                  cmd,
  output ssrg_pkg::status_t               status,
  input  logic [ssrg_pkg::KeyInW-1:0]     in_key,
  input  logic [ssrg_pkg::SeqW-1:0]       in_seq,
  input  logic [ssrg_pkg::TimeW-1:0]      in_now,
  input  logic                            cfg_we,
  input  logic [ssrg_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic [ssrg_pkg::CfgDataW-1:0]   cfg_data,
  output logic                            res_accepted,
  output logic                            res_new_session,
  output logic                            res_evicted
);

  localparam int unsigned AW = (N > 1) ? $clog2(N) : 1;
  localparam int unsigned CW = $clog2(N + 1);
  localparam logic [CW-1:0] NC = CW'(N);
  localparam logic [CW-1:0] LimitReset = (N < 16) ? CW'(N) : CW'(16);
  localparam logic [AW-1:0] LastIdx = AW'(N - 1);

  localparam int unsigned TW = ssrg_pkg::TimeW;
  localparam int unsigned SW = ssrg_pkg::SeqW;
  localparam int unsigned PW = ssrg_pkg::StampW;
  localparam int unsigned LimitInW_c = ssrg_pkg::LimitInW;

  // Table memories.
  logic [KW-1:0] key_mem   [N];
  logic [SW-1:0] seq_mem   [N];
  logic [TW-1:0] seen_mem  [N];
  logic [PW-1:0] stamp_mem [N];

  logic [N-1:0]  valid_r;
  logic [CW-1:0] count_r;
  logic [PW-1:0] stamp_ctr_r;
  logic [TW-1:0] ttl_r;
  logic [CW-1:0] limit_r;

  // Latched request.
  logic [KW-1:0] key_r;
  logic [SW-1:0] seq_r;
  logic [TW-1:0] now_r;

  // Scan pipeline.
  logic [CW-1:0] cnt_r;
  logic          ev_vld_r;
  logic [AW-1:0] ev_idx_r;
  logic [KW-1:0] rk_r;
  logic [SW-1:0] rs_r;
  logic [TW-1:0] rl_r;
  logic [PW-1:0] rt_r;

  // Scan results.
  logic          hit_r;
  logic [AW-1:0] hit_idx_r;
  logic [SW-1:0] hit_seq_r;
  logic          have_old_r;
  logic [AW-1:0] old_idx_r;
  logic [TW-1:0] old_seen_r;
  logic [PW-1:0] old_stamp_r;
  logic          have_free_r;
  logic [AW-1:0] free_idx_r;

  logic [63:0]   key_ext;
  logic          issue;
  logic          ev_valid, ev_exp, ev_live, ev_beats;
  logic [TW-1:0] ev_age;
  logic          seq_gt, do_evict;
  logic [AW-1:0] slot;
  logic [CW-1:0] cfg_lim;
  logic [LimitInW_c-1:0] lim_raw;

  assign key_ext = {32'd0, in_key};
  assign issue   = cmd.scan && (cnt_r < NC);

  // Evaluation of the entry read in the previous cycle.
  always_comb begin
    ev_valid = valid_r[ev_idx_r];
    ev_age   = now_r - rl_r;
    ev_exp   = ev_vld_r && ev_valid && (now_r >= rl_r) && (ev_age >= ttl_r);
    ev_live  = ev_vld_r && ev_valid && !ev_exp;
    ev_beats = !have_old_r || (rl_r < old_seen_r) ||
               ((rl_r == old_seen_r) && (rt_r < old_stamp_r));
  end

  assign status.scan_done = ev_vld_r && (ev_idx_r == LastIdx);

  // Commit decisions.
  always_comb begin
    seq_gt   = seq_r > hit_seq_r;
    do_evict = !hit_r && (count_r >= limit_r) && have_old_r;
    if (do_evict && (!have_free_r || (old_idx_r < free_idx_r))) begin
      slot = old_idx_r;
    end else begin
      slot = free_idx_r;
    end
  end

  // Clamp of a written session limit.
  always_comb begin
    lim_raw = cfg_data[LimitInW_c-1:0];
    if (lim_raw == '0) begin
      cfg_lim = CW'(1);
    end else if ({{(32-LimitInW_c){1'b0}}, lim_raw} > N) begin
      cfg_lim = NC;
    end else begin
      cfg_lim = CW'(lim_raw);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r   <= ssrg_pkg::TTL_RESET;
      limit_r <= LimitReset;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssrg_pkg::REG_TTL:   ttl_r <= cfg_data[TW-1:0];
        ssrg_pkg::REG_LIMIT: limit_r <= cfg_lim;
        default: ;
      endcase
    end
  end

  // Memory reads during the scan and writes at commit.
  always_ff @(posedge clk) begin
    if (issue) begin
      rk_r <= key_mem[cnt_r[AW-1:0]];
      rs_r <= seq_mem[cnt_r[AW-1:0]];
      rl_r <= seen_mem[cnt_r[AW-1:0]];
      rt_r <= stamp_mem[cnt_r[AW-1:0]];
    end
    if (cmd.commit) begin
      if (hit_r) begin
        seen_mem[hit_idx_r] <= now_r;
        if (seq_gt) begin
          seq_mem[hit_idx_r] <= seq_r;
        end
      end else begin
        key_mem[slot]   <= key_r;
        seq_mem[slot]   <= seq_r;
        seen_mem[slot]  <= now_r;
        stamp_mem[slot] <= stamp_ctr_r;
      end
    end
  end

  // Request latch and result registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= key_ext[KW-1:0];
      seq_r <= in_seq;
      now_r <= in_now;
    end
    if (cmd.commit) begin
      res_accepted    <= hit_r ? seq_gt : 1'b1;
      res_new_session <= !hit_r;
      res_evicted     <= do_evict;
    end
  end

  // Scan control, table occupancy and valid bits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      count_r     <= '0;
      stamp_ctr_r <= '0;
      cnt_r       <= '0;
      ev_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      have_old_r  <= 1'b0;
      have_free_r <= 1'b0;
    end else begin
      ev_vld_r <= issue;
      if (issue) begin
        ev_idx_r <= cnt_r[AW-1:0];
        cnt_r    <= cnt_r + CW'(1);
      end
      if (cmd.load) begin
        cnt_r       <= '0;
        hit_r       <= 1'b0;
        have_old_r  <= 1'b0;
        have_free_r <= 1'b0;
      end
      if (ev_exp) begin
        valid_r[ev_idx_r] <= 1'b0;
        count_r <= count_r - CW'(1);
      end
      if (ev_live && (rk_r == key_r)) begin
        hit_r     <= 1'b1;
        hit_idx_r <= ev_idx_r;
        hit_seq_r <= rs_r;
      end
      if (ev_live && ev_beats) begin
        have_old_r  <= 1'b1;
        old_idx_r   <= ev_idx_r;
        old_seen_r  <= rl_r;
        old_stamp_r <= rt_r;
      end
      if (ev_vld_r && !ev_live && !have_free_r) begin
        have_free_r <= 1'b1;
        free_idx_r  <= ev_idx_r;
      end
      if (cmd.commit && !hit_r) begin
        if (do_evict) begin
          valid_r[old_idx_r] <= 1'b0;
        end else begin
          count_r <= count_r + CW'(1);
        end
        valid_r[slot] <= 1'b1;
        stamp_ctr_r   <= stamp_ctr_r + PW'(1);
      end
    end
  end

endmodule

// ----- bench/tb_session_sequence_replay_guard.sv -----
`timescale 1ns / 100ps

module tb_session_sequence_replay_guard;

  localparam int unsigned NumSlots  = 16;
  localparam int unsigned DrainWait = NumSlots + 9;
  localparam logic [ssrg_pkg::CfgIdxW-1:0] REG_SPARE2 = 2'd2;
  localparam logic [ssrg_pkg::CfgIdxW-1:0] REG_SPARE3 = 2'd3;
  localparam int unsigned PoolSize = 24;

  typedef struct packed {
    logic accepted;
    logic new_session;
    logic evicted;
  } verdict_t;

  // Replay table predictor and the queue of verdicts it has produced.
  class replay_scoreboard;
    logic [ssrg_pkg::TimeW-1:0]   ttl;
    int unsigned                  limit;
    bit                           live [NumSlots];
    logic [ssrg_pkg::KeyInW-1:0]  key_of [NumSlots];
    logic [ssrg_pkg::SeqW-1:0]    top_seq [NumSlots];
    logic [ssrg_pkg::TimeW-1:0]   seen_at [NumSlots];
    int unsigned                  rank [NumSlots];
    int unsigned                  occupancy;
    verdict_t                     verdicts [$];
    int unsigned                  errors, checked, hits, stale, evictions;

    function new();
      ttl = ssrg_pkg::TTL_RESET;
      limit = NumSlots;
      occupancy = 0;
      errors = 0; checked = 0; hits = 0; stale = 0; evictions = 0;
      foreach (live[i]) live[i] = 0;
    endfunction

    function void write_reg(logic [ssrg_pkg::CfgIdxW-1:0] idx,
                            logic [ssrg_pkg::CfgDataW-1:0] data);
      int unsigned v;
      if (idx == ssrg_pkg::REG_TTL) begin
        ttl = data;
      end else if (idx == ssrg_pkg::REG_LIMIT) begin
        v = 32'(data[ssrg_pkg::LimitInW-1:0]);
        if (v == 0) v = 1;
        if (v > NumSlots) v = NumSlots;
        limit = v;
      end
    endfunction

    // Removing an entry closes the gap in the insertion order.
    function void drop(int s);
      live[s] = 0;
      foreach (live[i])
        if (live[i] && rank[i] > rank[s]) rank[i]--;
      if (occupancy > 0) occupancy--;
    endfunction

    function void note_request(logic [ssrg_pkg::KeyInW-1:0] k,
                               logic [ssrg_pkg::SeqW-1:0] sq,
                               logic [ssrg_pkg::TimeW-1:0] now);
      verdict_t v;
      int oldest, slot;
      logic [ssrg_pkg::TimeW-1:0] age;
      oldest = -1;
      slot = -1;
      // Expire idle entries; entries seen in the future are kept.
      for (int i = 0; i < NumSlots; i++) begin
        age = now - seen_at[i];
        if (live[i] && now >= seen_at[i] && age >= ttl) drop(i);
      end
      // Hit: refresh and accept only a strictly newer sequence.
      for (int i = 0; i < NumSlots; i++) begin
        if (live[i] && key_of[i] == k) begin
          seen_at[i] = now;
          v = '0;
          if (sq > top_seq[i]) begin
            top_seq[i] = sq;
            v.accepted = 1;
          end else begin
            stale++;
          end
          hits++;
          verdicts.insert(verdicts.size(), v);
          return;
        end
      end
      // Miss: evict the least recently seen entry when full.
      v = '{accepted: 1, new_session: 1, evicted: 0};
      if (occupancy >= limit) begin
        for (int i = 0; i < NumSlots; i++) begin
          if (live[i] && (oldest < 0 || seen_at[i] < seen_at[oldest] ||
              (seen_at[i] == seen_at[oldest] && rank[i] < rank[oldest])))
            oldest = i;
        end
        if (oldest >= 0) begin
          drop(oldest);
          v.evicted = 1;
          evictions++;
        end
      end
      for (int i = 0; i < NumSlots; i++) begin
        if (!live[i] && slot < 0) slot = i;
      end
      if (slot >= 0) begin
        live[slot] = 1;
        key_of[slot] = k;
        top_seq[slot] = sq;
        seen_at[slot] = now;
        rank[slot] = occupancy;
        occupancy++;
      end
      verdicts.insert(verdicts.size(), v);
    endfunction

    task report_mismatch(string what, logic got, logic want);
      errors++;
      $display("[%0t] mismatch on %s: got %0b, expected %0b", $time, what, got, want);
    endtask

    task check_result(verdict_t got);
      verdict_t want;
      checked++;
      if (verdicts.size() == 0) begin
        report_mismatch("result with none pending", 1'b1, 1'b0);
        return;
      end
      want = verdicts.pop_front();
      if (got.accepted !== want.accepted)
        report_mismatch("accepted", got.accepted, want.accepted);
      if (got.new_session !== want.new_session)
        report_mismatch("new_session", got.new_session, want.new_session);
      if (got.evicted !== want.evicted)
        report_mismatch("evicted", got.evicted, want.evicted);
    endtask

    function int unsigned pending();
      return verdicts.size();
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_we = 0;
  logic [ssrg_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [ssrg_pkg::CfgDataW-1:0] cfg_data = '0;

  ssrg_req_if req_if();
  ssrg_res_if res_if();

  replay_scoreboard guard_sb = new();

  logic [ssrg_pkg::KeyInW-1:0] key_pool [PoolSize];
  logic [ssrg_pkg::SeqW-1:0]   pool_seq [PoolSize];
  logic [ssrg_pkg::TimeW-1:0]  clock_now;
  int unsigned                 sent_count = 0;

  session_sequence_replay_guard dut (
    .clk(clk), .rst_n(rst_n), .in_ch(req_if), .out_ch(res_if),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  // Long receiver hold-off, counted here, so the block backs up behind it.
  logic rx_hold = 0;
  initial begin
    while (guard_sb.checked < 700) @(posedge clk);
    rx_hold <= 1;
    repeat (300) @(posedge clk);
    rx_hold <= 0;
  end

  // Result side: random stalls between results, none while results 300 to 450 are checked.
  int unsigned rx_wait = 0;
  always @(posedge clk) begin
    int unsigned w;
    w = rx_wait;
    if (!rst_n) begin
      res_if.ready <= 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        guard_sb.check_result('{res_if.accepted, res_if.new_session, res_if.evicted});
        if (guard_sb.checked inside {[300:450]}) w = 0;
        else w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 8);
      end else if (w > 0) begin
        w--;
      end
      rx_wait = w;
      if (rx_hold) begin
        res_if.ready <= 0;
      end else begin
        res_if.ready <= (w == 0);
      end
    end
  end

  // Offer one request after the given gap and wait until it is taken.
  task send_request(logic [ssrg_pkg::KeyInW-1:0] k, logic [ssrg_pkg::SeqW-1:0] sq,
                    logic [ssrg_pkg::TimeW-1:0] now, int unsigned gap);
    if (gap > 0) begin
      req_if.valid <= 0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid <= 1;
    req_if.session_key <= k;
    req_if.sequence_number <= sq;
    req_if.now_sec <= now;
    do @(posedge clk); while (!req_if.ready);
    guard_sb.note_request(k, sq, now);
    sent_count++;
  endtask

  task drain_block();
    req_if.valid <= 0;
    while (guard_sb.pending() > 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  task write_reg(logic [ssrg_pkg::CfgIdxW-1:0] idx, logic [ssrg_pkg::CfgDataW-1:0] data);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 0;
    guard_sb.write_reg(idx, data);
  endtask

  function int unsigned draw_gap(int unsigned n);
    if (n % 200 < 40) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
  endfunction

  // Mostly ordered traffic over a small key pool, some stale and some noise.
  task random_phase(int unsigned count);
    int unsigned p, pick;
    logic [ssrg_pkg::SeqW-1:0] sq;
    foreach (key_pool[i]) begin
      key_pool[i] = $urandom;
      pool_seq[i] = {$urandom, $urandom} >> $urandom_range(0, 63);
    end
    for (int unsigned n = 0; n < count; n++) begin
      if (n == count / 2 && count > 100) drain_block();
      pick = $urandom_range(0, 99);
      p = $urandom_range(0, PoolSize - 1);
      if (pick < 10) begin
        send_request($urandom, {$urandom, $urandom}, $urandom, draw_gap(n));
      end else begin
        if (pick < 15) clock_now = clock_now - $urandom_range(1, 20);
        else if (pick < 20) clock_now = clock_now + $urandom_range(20, 200);
        else clock_now = clock_now + $urandom_range(0, 3);
        if (pick < 30) begin
          sq = pool_seq[p] - $urandom_range(0, 3);
        end else begin
          sq = pool_seq[p] + $urandom_range(1, 9);
          pool_seq[p] = sq;
        end
        send_request(key_pool[p], sq, clock_now, draw_gap(n));
      end
    end
  endtask

  initial begin
    #10000000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    req_if.valid <= 0;
    req_if.session_key <= '0;
    req_if.sequence_number <= '0;
    req_if.now_sec <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1;
    repeat (NumSlots + 4) @(posedge clk);
    clock_now = 32'd1000;

    // Directed: new, newer, duplicate, older, sequence and key extremes.
    send_request(32'h0, 64'd5, clock_now, 0);
    send_request(32'h0, 64'd6, clock_now, 0);
    send_request(32'h0, 64'd6, clock_now, 1);
    send_request(32'h0, 64'd2, clock_now, 0);
    send_request(32'hFFFF_FFFF, 64'd0, clock_now, 0);
    send_request(32'hFFFF_FFFF, 64'd0, clock_now, 0);
    send_request(32'hFFFF_FFFF, '1, clock_now, 0);
    send_request(32'hFFFF_FFFF, '1, 32'hFFFF_FFFF, 2);
    // Time going backwards keeps the entry alive.
    send_request(32'h0, 64'd7, 32'd0, 0);
    // Expiry once the ttl has run out.
    send_request(32'h0, 64'd1, clock_now + 30, 0);
    // Fill past the limit with equal times so the insertion order breaks ties.
    for (int i = 0; i < 17; i++)
      send_request(32'h100 + i, 64'd1, 32'd5000, 0);
    drain_block();

    // Register extremes, unknown indexes and a limit below occupancy.
    write_reg(REG_SPARE2, 32'h0);
    write_reg(REG_SPARE3, 32'hFFFF_FFFF);
    write_reg(ssrg_pkg::REG_LIMIT, 32'd2);
    send_request(32'h200, 64'd1, 32'd5001, 0);
    send_request(32'h201, 64'd1, 32'd5001, 0);
    drain_block();

    write_reg(ssrg_pkg::REG_TTL, 32'd0);
    write_reg(ssrg_pkg::REG_LIMIT, 32'd0);
    clock_now = $urandom;
    random_phase(300);
    drain_block();

    write_reg(ssrg_pkg::REG_TTL, 32'd8);
    write_reg(ssrg_pkg::REG_LIMIT, 32'd4);
    random_phase(300);
    drain_block();

    write_reg(ssrg_pkg::REG_TTL, 32'hFFFF_FFFF);
    write_reg(ssrg_pkg::REG_LIMIT, 32'd31);
    random_phase(300);
    drain_block();

    write_reg(ssrg_pkg::REG_TTL, 32'd40);
    write_reg(ssrg_pkg::REG_LIMIT, 32'd17);
    random_phase(300);
    drain_block();

    write_reg(ssrg_pkg::REG_TTL, 32'd1);
    write_reg(ssrg_pkg::REG_LIMIT, 32'd1);
    random_phase(250);
    drain_block();

    write_reg(ssrg_pkg::REG_TTL, 32'd25);
    write_reg(ssrg_pkg::REG_LIMIT, 32'd9);
    random_phase(320);
    drain_block();

    $display("Sent %0d requests, %0d results: %0d hits (%0d stale), %0d evictions.",
             sent_count, guard_sb.checked, guard_sb.hits, guard_sb.stale,
             guard_sb.evictions);
    $display("Ttl from 0 to max and session limit from 1 to 16 were exercised.");
    if (guard_sb.errors == 0 && guard_sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/ssrg_pkg.sv
rtl/ssrg_if.sv
rtl/ssrg_ctrl.sv
rtl/ssrg_datapath.sv
rtl/session_sequence_replay_guard.sv
bench/tb_session_sequence_replay_guard.sv
